@@ rtl/assert_macros.svh @@
// Assertion helpers shared by the RTL.
// ASSERT_CLK: property checked on every rising edge outside reset.
// ASSERT_NEVER: the expression must never hold outside reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_CLK(name, clk, rstn, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

`define ASSERT_NEVER(name, clk, rstn, expr, msg) \
  `ASSERT_CLK(name, clk, rstn, !(expr), msg)

`endif

@@ rtl/lps_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package lps_pkg;

  localparam int unsigned COORD_BITS = 9;
  // error terms never exceed twice the major distance
  localparam int unsigned ERR_BITS   = COORD_BITS + 2;
  // pixel count reaches distance + 1
  localparam int unsigned CNT_BITS   = COORD_BITS + 1;
  localparam int unsigned COLOR_BITS = 16;

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [ERR_BITS-1:0]   err_t;
  typedef logic [CNT_BITS-1:0]   cnt_t;
  typedef logic [COLOR_BITS-1:0] color_t;

  typedef enum logic [0:0] {
    OP_START = 1'b0,
    OP_NEXT  = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    STEP_NONE = 2'd0,
    STEP_INC  = 2'd1,
    STEP_DEC  = 2'd3
  } step_e;

  typedef struct packed {
    op_e    operation;
    coord_t x_start;
    coord_t y_start;
    coord_t x_end;
    coord_t y_end;
    color_t color;
  } cmd_t;

  typedef struct packed {
    coord_t pixel_x;
    coord_t pixel_y;
    color_t pixel_color;
    logic   last_point;
  } pix_t;

  typedef struct packed {
    logic emit;
    pix_t pix;
  } res_t;

endpackage

`default_nettype wire

@@ rtl/lps_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface lps_cmd_if;
  logic                 valid;
  logic                 ready;
  logic                 operation;
  lps_pkg::coord_t      x_start;
  lps_pkg::coord_t      y_start;
  lps_pkg::coord_t      x_end;
  lps_pkg::coord_t      y_end;
  lps_pkg::color_t      color;

  modport source (output valid, operation, x_start, y_start, x_end, y_end, color,
                  input ready);
  modport sink   (input valid, operation, x_start, y_start, x_end, y_end, color,
                  output ready);
endinterface

interface lps_pix_if;
  logic                 valid;
  logic                 ready;
  lps_pkg::coord_t      pixel_x;
  lps_pkg::coord_t      pixel_y;
  lps_pkg::color_t      pixel_color;
  logic                 last_point;

  modport source (output valid, pixel_x, pixel_y, pixel_color, last_point,
                  input ready);
  modport sink   (input valid, pixel_x, pixel_y, pixel_color, last_point,
                  output ready);
endinterface

`default_nettype wire

@@ rtl/lps_stepper.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Line state and per-pixel step logic. State advances only on fire_i.
module lps_stepper (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          fire_i,
  input  wire lps_pkg::cmd_t cmd_i,
  output lps_pkg::res_t      res_o
);

  logic            active_q,  active_d;
  lps_pkg::coord_t cur_x_q,   cur_x_d;
  lps_pkg::coord_t cur_y_q,   cur_y_d;
  lps_pkg::err_t   err_x_q,   err_x_d;
  lps_pkg::err_t   err_y_q,   err_y_d;
  lps_pkg::coord_t abs_dx_q,  abs_dx_d;
  lps_pkg::coord_t abs_dy_q,  abs_dy_d;
  lps_pkg::coord_t major_q,   major_d;
  lps_pkg::step_e  step_x_q,  step_x_d;
  lps_pkg::step_e  step_y_q,  step_y_d;
  lps_pkg::cnt_t   left_q,    left_d;
  lps_pkg::color_t color_q,   color_d;

  lps_pkg::coord_t sdx, sdy, smajor;
  lps_pkg::step_e  sstx, ssty;
  lps_pkg::err_t   ex_sum, ey_sum, major_ext;
  logic            last;

  function automatic lps_pkg::coord_t apply_step(lps_pkg::coord_t c, lps_pkg::step_e s);
    lps_pkg::coord_t r;
    case (s)
      lps_pkg::STEP_INC: r = c + lps_pkg::coord_t'(1);
      lps_pkg::STEP_DEC: r = c - lps_pkg::coord_t'(1);
      default:           r = c;
    endcase
    return r;
  endfunction

  always_comb begin
    // start: per-axis delta and direction
    if (cmd_i.x_end > cmd_i.x_start) begin
      sdx  = cmd_i.x_end - cmd_i.x_start;
      sstx = lps_pkg::STEP_INC;
    end else if (cmd_i.x_end == cmd_i.x_start) begin
      sdx  = '0;
      sstx = lps_pkg::STEP_NONE;
    end else begin
      sdx  = cmd_i.x_start - cmd_i.x_end;
      sstx = lps_pkg::STEP_DEC;
    end
    if (cmd_i.y_end > cmd_i.y_start) begin
      sdy  = cmd_i.y_end - cmd_i.y_start;
      ssty = lps_pkg::STEP_INC;
    end else if (cmd_i.y_end == cmd_i.y_start) begin
      sdy  = '0;
      ssty = lps_pkg::STEP_NONE;
    end else begin
      sdy  = cmd_i.y_start - cmd_i.y_end;
      ssty = lps_pkg::STEP_DEC;
    end
    smajor = (sdx > sdy) ? sdx : sdy;

    // next: error accumulate
    major_ext = lps_pkg::err_t'(major_q);
    ex_sum    = err_x_q + lps_pkg::err_t'(abs_dx_q);
    ey_sum    = err_y_q + lps_pkg::err_t'(abs_dy_q);
    last      = (left_q <= lps_pkg::cnt_t'(1));

    active_d = active_q;
    cur_x_d  = cur_x_q;
    cur_y_d  = cur_y_q;
    err_x_d  = err_x_q;
    err_y_d  = err_y_q;
    abs_dx_d = abs_dx_q;
    abs_dy_d = abs_dy_q;
    major_d  = major_q;
    step_x_d = step_x_q;
    step_y_d = step_y_q;
    left_d   = left_q;
    color_d  = color_q;

    res_o.emit            = 1'b0;
    res_o.pix.pixel_x     = cur_x_q;
    res_o.pix.pixel_y     = cur_y_q;
    res_o.pix.pixel_color = color_q;
    res_o.pix.last_point  = 1'b0;

    unique case (cmd_i.operation)
      lps_pkg::OP_START: begin
        res_o.emit            = 1'b1;
        res_o.pix.pixel_x     = cmd_i.x_start;
        res_o.pix.pixel_y     = cmd_i.y_start;
        res_o.pix.pixel_color = cmd_i.color;
        active_d = 1'b1;
        cur_x_d  = cmd_i.x_start;
        cur_y_d  = cmd_i.y_start;
        abs_dx_d = sdx;
        abs_dy_d = sdy;
        major_d  = smajor;
        step_x_d = sstx;
        step_y_d = ssty;
        color_d  = cmd_i.color;
        left_d   = lps_pkg::cnt_t'(smajor) + lps_pkg::cnt_t'(1);
        // error starts at the delta: an axis steps on the first advance
        // if twice its delta exceeds major; the start pixel still repeats
        err_x_d  = lps_pkg::err_t'(sdx);
        err_y_d  = lps_pkg::err_t'(sdy);
      end
      lps_pkg::OP_NEXT: begin
        if (active_q) begin
          res_o.emit           = 1'b1;
          res_o.pix.last_point = last;
          if (last) begin
            left_d   = '0;
            active_d = 1'b0;
          end else begin
            left_d  = left_q - lps_pkg::cnt_t'(1);
            err_x_d = ex_sum;
            err_y_d = ey_sum;
            if (ex_sum > major_ext) begin
              err_x_d = ex_sum - major_ext;
              cur_x_d = apply_step(cur_x_q, step_x_q);
            end
            if (ey_sum > major_ext) begin
              err_y_d = ey_sum - major_ext;
              cur_y_d = apply_step(cur_y_q, step_y_q);
            end
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      cur_x_q  <= '0;
      cur_y_q  <= '0;
      err_x_q  <= '0;
      err_y_q  <= '0;
      abs_dx_q <= '0;
      abs_dy_q <= '0;
      major_q  <= '0;
      step_x_q <= lps_pkg::STEP_NONE;
      step_y_q <= lps_pkg::STEP_NONE;
      left_q   <= '0;
      color_q  <= '0;
    end else if (fire_i) begin
      active_q <= active_d;
      cur_x_q  <= cur_x_d;
      cur_y_q  <= cur_y_d;
      err_x_q  <= err_x_d;
      err_y_q  <= err_y_d;
      abs_dx_q <= abs_dx_d;
      abs_dy_q <= abs_dy_d;
      major_q  <= major_d;
      step_x_q <= step_x_d;
      step_y_q <= step_y_d;
      left_q   <= left_d;
      color_q  <= color_d;
    end
  end

endmodule

`default_nettype wire

@@ rtl/line_pixel_stepper_top.sv @@
// A transferred command is held in the command register, and its pixel then in the pixel register, which drives pix_o.
// Throughput: one command per cycle unless a pixel waits on pix_o; the step is two error adds and compares on
// registered state, between the command register and the pixel register.
// A next command with no line in progress is consumed and gives no pixel.
// Reset (rst_ni low, asynchronous): both stage registers empty, no line active.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module line_pixel_stepper_top (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  lps_cmd_if.sink     cmd_i,
  lps_pix_if.source   pix_o
);

  // Stage 1: command register
  logic          cmd_valid_q;
  lps_pkg::cmd_t cmd_q, cmd_d;

  // Stage 2: pixel register
  logic          pix_valid_q;
  lps_pkg::pix_t pix_q;

  lps_pkg::res_t res;
  logic          out_free;   // pixel register may load this cycle
  logic          s2_go;      // staged command is consumed by the stepper
  logic          cmd_xfer;

  assign out_free = !pix_valid_q || pix_o.ready;
  // a command with no pixel never waits for the output side
  assign s2_go    = cmd_valid_q && (out_free || !res.emit);

  assign cmd_i.ready = !cmd_valid_q || s2_go;
  assign cmd_xfer    = cmd_i.valid && cmd_i.ready;

  always_comb begin
    cmd_d.operation = lps_pkg::op_e'(cmd_i.operation);
    cmd_d.x_start   = cmd_i.x_start;
    cmd_d.y_start   = cmd_i.y_start;
    cmd_d.x_end     = cmd_i.x_end;
    cmd_d.y_end     = cmd_i.y_end;
    cmd_d.color     = cmd_i.color;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_valid_q <= 1'b0;
    end else if (cmd_i.ready) begin
      cmd_valid_q <= cmd_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_xfer) begin
      cmd_q <= cmd_d;
    end
  end

  lps_stepper u_stepper (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (s2_go),
    .cmd_i  (cmd_q),
    .res_o  (res)
  );

  // pixel register: loads on an emitting command, holds while stalled
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pix_valid_q <= 1'b0;
    end else if (out_free) begin
      pix_valid_q <= cmd_valid_q && res.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && cmd_valid_q && res.emit) begin
      pix_q <= res.pix;
    end
  end

  assign pix_o.valid       = pix_valid_q;
  assign pix_o.pixel_x     = pix_q.pixel_x;
  assign pix_o.pixel_y     = pix_q.pixel_y;
  assign pix_o.pixel_color = pix_q.pixel_color;
  assign pix_o.last_point  = pix_q.last_point;

  // a pixel appears only from a command staged the cycle before
  `ASSERT_CLK(a_pix_from_stage, clk_i, rst_ni, $rose(pix_valid_q) |-> $past(cmd_valid_q), "pixel without staged command")
  // a command with no pixel must not fill a free output
  `ASSERT_CLK(a_no_phantom_pix, clk_i, rst_ni, (cmd_valid_q && !res.emit && out_free) |=> !pix_valid_q, "phantom pixel")
  // every start command gives a pixel
  `ASSERT_NEVER(a_start_emits, clk_i, rst_ni, s2_go && (cmd_q.operation == lps_pkg::OP_START) && !res.emit, "start without pixel")

endmodule

`default_nettype wire
